// ----- rtl/core/pchc_pkg.sv -----
// Shared types and constants for the point cloud height cut / centroid block.
// No dependencies; the RTL files refer to it by scoped names, the testbench imports it.
package pchc_pkg;

    localparam int COORD_W     = 24;                       // signed Q8.16
    localparam int COUNT_W     = 21;
    localparam int MAX_POINTS  = 1048576;
    localparam int SUM_W       = COORD_W + COUNT_W - 1;    // 44
    localparam int IN_DATA_W   = 3 * COORD_W;              // 72, whole bytes
    localparam int OUT_FIELD_W = 3 * COORD_W + 2 * COUNT_W;
    localparam int OUT_DATA_W  = ((OUT_FIELD_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_DATA_W - OUT_FIELD_W;
    localparam int OUT_USER_W  = 2;

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // quotient magnitude never exceeds 2^(COORD_W-1), so COORD_W steps suffice
    localparam int DIV_STEPS   = COORD_W;
    localparam int STEP_W      = $clog2(DIV_STEPS);

    localparam logic KIND_POINT    = 1'b0;
    localparam logic KIND_CENTROID = 1'b1;

    // one classified point handed from front to back
    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic               kept;
        logic               avg;
        logic               last;
    } cmd_t;

    typedef struct packed {
        logic                    start;
        logic signed [SUM_W-1:0] dividend;
        logic [COUNT_W-1:0]      divisor;
    } div_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [COORD_W-1:0] quotient;
    } div_rsp_t;

endpackage

// ----- rtl/core/pchc_front.sv -----
// Front end: threshold register, input beat acceptance and classification.
// Depends on pchc_pkg; feeds pchc_queue.
module pchc_front
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [pchc_pkg::COORD_W-1:0]  cfg_wr_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [pchc_pkg::IN_DATA_W-1:0] s_tdata,
    input  logic                          s_tlast,
    input  logic                          q_full,
    output logic                          q_push,
    output pchc_pkg::cmd_t                q_data
);

    logic signed [pchc_pkg::COORD_W-1:0] threshold_reg;
    logic signed [pchc_pkg::COORD_W-1:0] px;
    logic signed [pchc_pkg::COORD_W-1:0] py;
    logic signed [pchc_pkg::COORD_W-1:0] pz;
    logic                                keep;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= '0;
        end
        else if (cfg_wr_en)
        begin
            threshold_reg <= cfg_wr_data;
        end
    end

    assign px   = s_tdata[pchc_pkg::COORD_W-1:0];
    assign py   = s_tdata[2*pchc_pkg::COORD_W-1:pchc_pkg::COORD_W];
    assign pz   = s_tdata[3*pchc_pkg::COORD_W-1:2*pchc_pkg::COORD_W];
    assign keep = py < threshold_reg;

    assign s_tready = !q_full;
    // points that are neither kept nor last leave no trace
    assign q_push   = s_tvalid && !q_full && (keep || s_tlast);

    always_comb
    begin
        q_data.x    = px;
        q_data.y    = py;
        q_data.z    = pz;
        q_data.kept = keep;
        q_data.avg  = keep && (px != '0) && (py != '0) && (pz != '0);
        q_data.last = s_tlast;
    end

endmodule

// ----- rtl/core/pchc_queue.sv -----
// Short command queue between front and back end.
// Depends on pchc_pkg for the entry type and depth.
module pchc_queue
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  pchc_pkg::cmd_t push_data,
    output logic           full,
    input  logic           pop,
    output pchc_pkg::cmd_t pop_data,
    output logic           empty
);

    pchc_pkg::cmd_t                   entry_reg [pchc_pkg::QUEUE_DEPTH];
    logic [pchc_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [pchc_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [pchc_pkg::QCNT_W-1:0]      count_reg;
    logic [pchc_pkg::QCNT_W-1:0]      count_next;
    logic                             do_push;
    logic                             do_pop;

    assign full     = count_reg == pchc_pkg::QCNT_W'(pchc_pkg::QUEUE_DEPTH);
    assign empty    = count_reg == '0;
    assign do_push  = push && !full;
    assign do_pop   = pop && !empty;
    assign pop_data = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

endmodule

// ----- rtl/core/pchc_divider.sv -----
// Radix-2 restoring divider, signed sum by unsigned count, truncating toward zero.
// Depends on pchc_pkg; shared by the three centroid axes.
module pchc_divider
(
    input  logic               clk,
    input  logic               rst_n,
    input  pchc_pkg::div_req_t req,
    output pchc_pkg::div_rsp_t rsp
);

    logic                               busy_reg;
    logic                               done_reg;
    logic                               neg_reg;
    logic [pchc_pkg::COUNT_W-1:0]       rem_reg;
    logic [pchc_pkg::COORD_W-1:0]       low_reg;
    logic [pchc_pkg::COORD_W-1:0]       quo_reg;
    logic [pchc_pkg::COUNT_W-1:0]       divisor_reg;
    logic [pchc_pkg::STEP_W-1:0]        step_reg;
    logic [pchc_pkg::SUM_W-1:0]         mag;
    logic [pchc_pkg::COUNT_W:0]         trial;
    logic                               qbit;
    logic [pchc_pkg::COUNT_W-1:0]       rem_next;

    // |sum| <= count * 2^(COORD_W-1), so the high part starts below the divisor
    assign mag   = req.dividend[pchc_pkg::SUM_W-1] ? (~req.dividend + 1'b1) : req.dividend;
    assign trial = {rem_reg, low_reg[pchc_pkg::COORD_W-1]};
    assign qbit  = trial >= {1'b0, divisor_reg};

    always_comb
    begin
        if (qbit)
        begin
            rem_next = pchc_pkg::COUNT_W'(trial - {1'b0, divisor_reg});
        end
        else
        begin
            rem_next = trial[pchc_pkg::COUNT_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            neg_reg     <= req.dividend[pchc_pkg::SUM_W-1];
            rem_reg     <= {1'b0, mag[pchc_pkg::SUM_W-1:pchc_pkg::COORD_W]};
            low_reg     <= mag[pchc_pkg::COORD_W-1:0];
            quo_reg     <= '0;
            divisor_reg <= req.divisor;
            step_reg    <= pchc_pkg::STEP_W'(pchc_pkg::DIV_STEPS - 1);
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_next;
            low_reg  <= {low_reg[pchc_pkg::COORD_W-2:0], 1'b0};
            quo_reg  <= {quo_reg[pchc_pkg::COORD_W-2:0], qbit};
            step_reg <= step_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
            end
            else if (busy_reg && step_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    assign rsp.done     = done_reg;
    assign rsp.quotient = neg_reg ? (~quo_reg + 1'b1) : quo_reg;

endmodule

// ----- rtl/core/pchc_back.sv -----
// Back end: accumulators, centroid sequencing and the output register.
// Depends on pchc_pkg; drains pchc_queue and drives pchc_divider.
module pchc_back
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  pchc_pkg::cmd_t                   q_data,
    input  logic                             q_empty,
    output logic                             q_pop,
    output pchc_pkg::div_req_t               div_req,
    input  pchc_pkg::div_rsp_t               div_rsp,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    output logic [pchc_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [pchc_pkg::OUT_USER_W-1:0]  m_tuser,
    output logic                             m_tlast
);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_POINT = 3'd1;
    localparam logic [2:0] ST_START = 3'd2;
    localparam logic [2:0] ST_DIV   = 3'd3;
    localparam logic [2:0] ST_CENT  = 3'd4;

    localparam logic [1:0] AXIS_X = 2'd0;
    localparam logic [1:0] AXIS_Y = 2'd1;
    localparam logic [1:0] AXIS_Z = 2'd2;

    localparam logic [pchc_pkg::COUNT_W-1:0] CNT_MAX =
        pchc_pkg::COUNT_W'(pchc_pkg::MAX_POINTS);

    logic [2:0]                           state_reg, state_next;
    pchc_pkg::cmd_t                       cmd_reg, cmd_next;
    logic signed [pchc_pkg::SUM_W-1:0]    sum_x_reg, sum_x_next;
    logic signed [pchc_pkg::SUM_W-1:0]    sum_y_reg, sum_y_next;
    logic signed [pchc_pkg::SUM_W-1:0]    sum_z_reg, sum_z_next;
    logic [pchc_pkg::COUNT_W-1:0]         kept_cnt_reg, kept_cnt_next;
    logic [pchc_pkg::COUNT_W-1:0]         avg_cnt_reg, avg_cnt_next;
    logic [1:0]                           axis_reg, axis_next;
    logic [pchc_pkg::COORD_W-1:0]         cx_reg, cx_next;
    logic [pchc_pkg::COORD_W-1:0]         cy_reg, cy_next;
    logic [pchc_pkg::COORD_W-1:0]         cz_reg, cz_next;
    logic                                 m_valid_reg, m_valid_next;
    logic [pchc_pkg::OUT_DATA_W-1:0]      m_data_reg, m_data_next;
    logic [pchc_pkg::OUT_USER_W-1:0]      m_user_reg, m_user_next;
    logic                                 m_last_reg, m_last_next;
    logic                                 out_free;
    logic [1:0]                           div_axis;

    assign out_free = !m_valid_reg || m_tready;

    always_comb
    begin
        state_next    = state_reg;
        cmd_next      = cmd_reg;
        sum_x_next    = sum_x_reg;
        sum_y_next    = sum_y_reg;
        sum_z_next    = sum_z_reg;
        kept_cnt_next = kept_cnt_reg;
        avg_cnt_next  = avg_cnt_reg;
        axis_next     = axis_reg;
        cx_next       = cx_reg;
        cy_next       = cy_reg;
        cz_next       = cz_reg;
        m_valid_next  = m_valid_reg && !m_tready;
        m_data_next   = m_data_reg;
        m_user_next   = m_user_reg;
        m_last_next   = m_last_reg;
        q_pop         = 1'b0;
        div_req.start = 1'b0;
        div_axis      = axis_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (!q_empty)
                begin
                    q_pop    = 1'b1;
                    cmd_next = q_data;
                    if (q_data.kept && kept_cnt_reg < CNT_MAX)
                    begin
                        kept_cnt_next = kept_cnt_reg + 1'b1;
                    end
                    // sums stop growing once the average count saturates
                    if (q_data.avg && avg_cnt_reg < CNT_MAX)
                    begin
                        sum_x_next   = sum_x_reg + pchc_pkg::SUM_W'($signed(q_data.x));
                        sum_y_next   = sum_y_reg + pchc_pkg::SUM_W'($signed(q_data.y));
                        sum_z_next   = sum_z_reg + pchc_pkg::SUM_W'($signed(q_data.z));
                        avg_cnt_next = avg_cnt_reg + 1'b1;
                    end
                    state_next = q_data.kept ? ST_POINT : ST_START;
                end
            end
            ST_POINT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {pchc_pkg::OUT_PAD_W'(0), {2 * pchc_pkg::COUNT_W{1'b0}},
                                    cmd_reg.z, cmd_reg.y, cmd_reg.x};
                    m_user_next  = {1'b0, pchc_pkg::KIND_POINT};
                    m_last_next  = 1'b0;
                    state_next   = cmd_reg.last ? ST_START : ST_IDLE;
                end
            end
            ST_START:
            begin
                axis_next = AXIS_X;
                div_axis  = AXIS_X;
                if (avg_cnt_reg == '0)
                begin
                    cx_next    = '0;
                    cy_next    = '0;
                    cz_next    = '0;
                    state_next = ST_CENT;
                end
                else
                begin
                    div_req.start = 1'b1;
                    state_next    = ST_DIV;
                end
            end
            ST_DIV:
            begin
                if (div_rsp.done)
                begin
                    case (axis_reg)
                        AXIS_X:  cx_next = div_rsp.quotient;
                        AXIS_Y:  cy_next = div_rsp.quotient;
                        default: cz_next = div_rsp.quotient;
                    endcase
                    if (axis_reg == AXIS_Z)
                    begin
                        state_next = ST_CENT;
                    end
                    else
                    begin
                        axis_next     = axis_reg + 1'b1;
                        div_axis      = axis_reg + 1'b1;
                        div_req.start = 1'b1;
                    end
                end
            end
            ST_CENT:
            begin
                if (out_free)
                begin
                    m_valid_next  = 1'b1;
                    m_data_next   = {pchc_pkg::OUT_PAD_W'(0), avg_cnt_reg, kept_cnt_reg,
                                     cz_reg, cy_reg, cx_reg};
                    m_user_next   = {avg_cnt_reg == '0, pchc_pkg::KIND_CENTROID};
                    m_last_next   = 1'b1;
                    sum_x_next    = '0;
                    sum_y_next    = '0;
                    sum_z_next    = '0;
                    kept_cnt_next = '0;
                    avg_cnt_next  = '0;
                    state_next    = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        case (div_axis)
            AXIS_X:  div_req.dividend = sum_x_reg;
            AXIS_Y:  div_req.dividend = sum_y_reg;
            default: div_req.dividend = sum_z_reg;
        endcase
        div_req.divisor = avg_cnt_reg;
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        cx_reg     <= cx_next;
        cy_reg     <= cy_next;
        cz_reg     <= cz_next;
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            sum_x_reg    <= '0;
            sum_y_reg    <= '0;
            sum_z_reg    <= '0;
            kept_cnt_reg <= '0;
            avg_cnt_reg  <= '0;
            axis_reg     <= AXIS_X;
            m_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            sum_x_reg    <= sum_x_next;
            sum_y_reg    <= sum_y_next;
            sum_z_reg    <= sum_z_next;
            kept_cnt_reg <= kept_cnt_next;
            avg_cnt_reg  <= avg_cnt_next;
            axis_reg     <= axis_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

endmodule

// ----- rtl/core/point_cloud_height_cut_centroid.sv -----
// Top level of the point cloud height cut / centroid block.
// Depends on pchc_pkg, pchc_front, pchc_queue, pchc_divider and pchc_back.
//
// Points (signed Q8.16 x, y, z) stream in one beat each, tlast marking the last
// point of a cloud. A point with y strictly below the threshold register is
// passed out as a point beat; kept points with x, y and z all nonzero are summed
// and counted. After the last point a centroid beat follows (tlast high) with
// each sum divided by the averaged count, truncated toward zero, plus the kept
// and averaged counts; if nothing was averaged the centroid reads zero and the
// none_averaged flag is set. Accumulators then clear. Counts saturate at 2^20;
// points beyond that still pass but no longer enter the average.
// Timing: the input takes one beat per cycle as long as the 4-entry command
// queue has room. Points that are neither kept nor last are dropped at the
// input and cost nothing downstream. The back end dequeues each kept point and
// then loads it into the output register. At a cloud end the centroid comes
// from the single shared radix-2 divider that resolves one quotient bit per
// cycle for x, y and z in turn (skipped when nothing was averaged). The output
// register lets the next item be dequeued while a finished beat waits for
// m_tready.
module point_cloud_height_cut_centroid
(
    input  logic                             clk,
    input  logic                             rst_n,
    // threshold register, signed Q8.16
    input  logic                             cfg_wr_en,
    input  logic [pchc_pkg::COORD_W-1:0]     cfg_wr_data,
    // input points
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [pchc_pkg::IN_DATA_W-1:0]   s_tdata,   // coord_x, coord_y, coord_z
    input  logic                             s_tlast,   // end_of_cloud
    // results
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // out_x, out_y, out_z, kept_total, averaged_total, zero pad
    output logic [pchc_pkg::OUT_DATA_W-1:0]  m_tdata,
    output logic [pchc_pkg::OUT_USER_W-1:0]  m_tuser,   // result_kind, none_averaged
    output logic                             m_tlast    // final_result
);

    logic               q_push;
    pchc_pkg::cmd_t     q_push_data;
    logic               q_full;
    logic               q_pop;
    pchc_pkg::cmd_t     q_pop_data;
    logic               q_empty;
    pchc_pkg::div_req_t div_req;
    pchc_pkg::div_rsp_t div_rsp;

    // classify at the input, so the threshold in force at acceptance applies
    pchc_front u_front
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_push_data)
    );

    pchc_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (q_pop_data),
        .empty     (q_empty)
    );

    pchc_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .rsp   (div_rsp)
    );

    pchc_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_data   (q_pop_data),
        .q_empty  (q_empty),
        .q_pop    (q_pop),
        .div_req  (div_req),
        .div_rsp  (div_rsp),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

// ----- rtl/core/pchc_checker.sv -----
// Port-level checks on the result stream of the height cut / centroid block.
// Depends on pchc_pkg; bound to point_cloud_height_cut_centroid below.
module pchc_checker
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             m_tvalid,
    input  logic                             m_tready,
    input  logic [pchc_pkg::OUT_DATA_W-1:0]  m_tdata,
    input  logic [pchc_pkg::OUT_USER_W-1:0]  m_tuser,
    input  logic                             m_tlast
);

    localparam int CNT_LO = 3 * pchc_pkg::COORD_W;
    localparam int CNT_HI = 3 * pchc_pkg::COORD_W + 2 * pchc_pkg::COUNT_W - 1;
    localparam int AVG_LO = 3 * pchc_pkg::COORD_W + pchc_pkg::COUNT_W;

    // stalled result beat holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // point beats carry no counts, flags or tlast
    a_point_clean: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] == pchc_pkg::KIND_POINT |->
        !m_tlast && !m_tuser[1] && m_tdata[CNT_HI:CNT_LO] == '0)
        else $error("point beat with centroid fields set");

    // centroid beat is always the cloud's last
    a_cent_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[0] == pchc_pkg::KIND_CENTROID |-> m_tlast)
        else $error("centroid beat without tlast");

    // empty average reads zero coordinates and a zero averaged count
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser[1] |->
        m_tdata[CNT_HI:AVG_LO] == '0 && m_tdata[CNT_LO-1:0] == '0)
        else $error("empty centroid with nonzero values");

endmodule

bind point_cloud_height_cut_centroid pchc_checker u_pchc_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ----- sim/tb.sv -----
// Testbench for point_cloud_height_cut_centroid: streams point clouds and checks
// every result beat against an in-bench model of the cut and centroid logic or, for pinned rows, typed-in values.
// Depends on pchc_pkg and the block's RTL only.
module tb;

    import pchc_pkg::*;

    localparam int C_MAX         = 8388607;
    localparam int C_MIN         = -8388608;
    localparam int RANDOM_ITEMS  = 850;
    localparam int SETTLE_CYCLES = 100;   // above the centroid latency
    localparam int REPORT_LIMIT  = 10;

    // one result beat, unpacked from m_tdata / m_tuser / m_tlast
    typedef struct packed {
        logic               kind;
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] z;
        logic [COUNT_W-1:0] kept;
        logic [COUNT_W-1:0] avg;
        logic               none;
        logic               fin;
    } beat_t;

    typedef enum logic {ROW_POINT, ROW_CFG} row_op_t;

    // directed row: a point, or a threshold write (value in x); pin marks a
    // row whose centroid beat is typed in below instead of predicted
    typedef struct packed {
        row_op_t op;
        int      x;
        int      y;
        int      z;
        bit      last;
        bit      pin;
        int      cx;
        int      cy;
        int      cz;
        int      ck;
        int      ca;
        bit      none;
    } dir_row_t;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [COORD_W-1:0]     cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_DATA_W-1:0]   s_tdata;    // coord_x, coord_y, coord_z
    logic                   s_tlast;    // end_of_cloud
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_DATA_W-1:0]  m_tdata;    // out_x, out_y, out_z, kept_total, averaged_total
    logic [OUT_USER_W-1:0]  m_tuser;    // result_kind, none_averaged
    logic                   m_tlast;    // final_result

    // model state
    logic signed [COORD_W-1:0] cut_level;
    longint                    acc_x;
    longint                    acc_y;
    longint                    acc_z;
    longint                    kept_seen;
    longint                    avg_seen;
    beat_t                     expected_beats[$];

    int mismatches;
    int beats_seen;
    int src_idle_pct;
    int sink_idle_pct;

    dir_row_t dir_rows [21] = '{
        // after reset, threshold 0: empty cloud
        '{ROW_POINT, 0, 0, 0, 1'b1, 1'b1, 0, 0, 0, 0, 0, 1'b1},
        // extremes; the two zero-bearing points pass but are not averaged;
        // sums -1 / -8388609 / -1 over 2 truncate toward zero
        '{ROW_POINT, C_MAX, C_MIN, C_MAX, 1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_POINT, C_MIN, -1, C_MIN, 1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_POINT, 5, C_MAX, 5, 1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_POINT, 0, -5, 7, 1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_POINT, 3, -5, 0, 1'b1, 1'b1, 0, -4194304, 0, 4, 2, 1'b0},
        '{ROW_POINT, C_MIN, C_MIN, C_MIN, 1'b1, 1'b1, C_MIN, C_MIN, C_MIN, 1, 1, 1'b0},
        '{ROW_CFG, C_MAX, 0, 0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_POINT, C_MAX, C_MAX - 1, C_MAX, 1'b1, 1'b1, C_MAX, C_MAX - 1, C_MAX, 1, 1, 1'b0},
        '{ROW_POINT, 1, 2, 3, 1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_POINT, 9, C_MAX, 9, 1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0},    // y equal: dropped
        // threshold change in the middle of a cloud
        '{ROW_CFG, C_MIN, 0, 0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_POINT, 1, C_MIN, 1, 1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_POINT, 4, 4, 4, 1'b1, 1'b1, 1, 2, 3, 1, 1, 1'b0},
        '{ROW_CFG, 256, 0, 0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_POINT, -100, 255, 300, 1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_POINT, 7, -7, -7, 1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_POINT, -1, 256, -1, 1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_POINT, 0, 0, 0, 1'b0, 1'b0, 0, 0, 0, 0, 0, 1'b0},
        '{ROW_POINT, -3, -1, -2, 1'b1, 1'b0, 0, 0, 0, 0, 0, 1'b0},
        // kept but nothing averaged
        '{ROW_POINT, 0, -9, 0, 1'b1, 1'b1, 0, 0, 0, 1, 0, 1'b1}
    };

    point_cloud_height_cut_centroid i_dut
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // hard stop for a hung run
    initial
    begin
        #(20 * 1000000);
        $display("tb: errors");
        $finish;
    end

    // Model of one accepted point: a kept-point beat if y is below the cut,
    // then the centroid beat on the last point of the cloud.
    function automatic void predict_beats(input logic signed [COORD_W-1:0] px, py, pz,
                                          input logic plast, input bit pin,
                                          input beat_t pinned);
        beat_t b;
        b = '0;
        if (py < cut_level)
        begin
            b.kind = KIND_POINT;
            b.x    = px;
            b.y    = py;
            b.z    = pz;
            expected_beats.push_back(b);
            if (kept_seen < MAX_POINTS)
                kept_seen++;
            // averaging stops at the count limit so the mean stays exact
            if (px != 0 && py != 0 && pz != 0 && avg_seen < MAX_POINTS)
            begin
                acc_x += longint'(px);
                acc_y += longint'(py);
                acc_z += longint'(pz);
                avg_seen++;
            end
        end
        if (plast)
        begin
            b      = '0;
            b.kind = KIND_CENTROID;
            if (avg_seen != 0)
            begin
                // longint division truncates toward zero
                b.x = COORD_W'(acc_x / avg_seen);
                b.y = COORD_W'(acc_y / avg_seen);
                b.z = COORD_W'(acc_z / avg_seen);
            end
            b.kept = COUNT_W'(kept_seen);
            b.avg  = COUNT_W'(avg_seen);
            b.none = (avg_seen == 0);
            b.fin  = 1'b1;
            expected_beats.push_back(pin ? pinned : b);
            acc_x     = 0;
            acc_y     = 0;
            acc_z     = 0;
            kept_seen = 0;
            avg_seen  = 0;
        end
    endfunction

    function automatic logic signed [COORD_W-1:0] pick_coord();
        case ($urandom_range(7))
            0:       return '0;
            1:       return COORD_W'(C_MAX);
            2:       return COORD_W'(C_MIN);
            3, 4:    return COORD_W'($urandom());
            default: return COORD_W'($urandom_range(262143) - 131072);
        endcase
    endfunction

    // y mostly just below the cut so most points are kept
    function automatic logic signed [COORD_W-1:0] pick_height();
        int roll;
        int h;
        roll = $urandom_range(19);
        h    = int'(cut_level) - int'($urandom_range(1, 65536));
        if (roll == 0)
            return cut_level;
        if (roll < 12 && h >= C_MIN)
            return COORD_W'(h);
        return pick_coord();
    endfunction

    function automatic logic [COORD_W-1:0] pick_threshold();
        case ($urandom_range(9))
            0:       return COORD_W'(C_MIN);
            1:       return COORD_W'(C_MAX);
            2:       return '0;
            3:       return COORD_W'($urandom());
            default: return COORD_W'($urandom_range(524287) - 262144);
        endcase
    endfunction

    // one point beat; tvalid stays high after acceptance until the next call
    // or a drain lowers it
    task automatic send_point(input logic signed [COORD_W-1:0] px, py, pz,
                              input logic plast, input bit pin, input beat_t pinned);
        while ($urandom_range(99) < src_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {pz, py, px};
        s_tlast  <= plast;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        predict_beats(px, py, pz, plast, pin, pinned);
    endtask

    // sender holds off until every expected beat is out, then lets dropped
    // points and a pending centroid settle
    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_threshold(input logic [COORD_W-1:0] value);
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge clk);
        cfg_wr_en   <= 1'b0;
        cut_level    = value;
    endtask

    // receiver side stalls
    always @(posedge clk)
        m_tready <= ($urandom_range(99) >= sink_idle_pct);

    // result checker: each beat against the oldest expectation
    always @(posedge clk)
    begin
        beat_t got;
        beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.x    = m_tdata[0 +: COORD_W];
            got.y    = m_tdata[COORD_W +: COORD_W];
            got.z    = m_tdata[2*COORD_W +: COORD_W];
            got.kept = m_tdata[3*COORD_W +: COUNT_W];
            got.avg  = m_tdata[3*COORD_W + COUNT_W +: COUNT_W];
            got.kind = m_tuser[0];
            got.none = m_tuser[1];
            got.fin  = m_tlast;
            if (expected_beats.size() == 0)
            begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("tb: unexpected beat %0d kind %0d x %h y %h z %h",
                             beats_seen, got.kind, got.x, got.y, got.z);
            end
            else
            begin
                want = expected_beats.pop_front();
                if (got.kind !== want.kind || got.x !== want.x || got.y !== want.y ||
                    got.z !== want.z || got.kept !== want.kept || got.avg !== want.avg ||
                    got.none !== want.none || got.fin !== want.fin)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                    begin
                        $display("tb: beat %0d mismatch (expected / actual)", beats_seen);
                        $display("  kind %0d/%0d x %h/%h y %h/%h z %h/%h",
                                 want.kind, got.kind, want.x, got.x,
                                 want.y, got.y, want.z, got.z);
                        $display("  kept %0d/%0d avg %0d/%0d none %0d/%0d last %0d/%0d",
                                 want.kept, got.kept, want.avg, got.avg,
                                 want.none, got.none, want.fin, got.fin);
                    end
                end
            end
            beats_seen++;
        end
    end

    initial
    begin
        beat_t pinned;
        beat_t no_pin;
        logic signed [COORD_W-1:0] px;
        logic signed [COORD_W-1:0] py;
        logic signed [COORD_W-1:0] pz;
        int sent;
        int len;
        int mid_cut;

        rst_n         <= 1'b0;
        cfg_wr_en     <= 1'b0;
        cfg_wr_data   <= '0;
        s_tvalid      <= 1'b0;
        s_tdata       <= '0;
        s_tlast       <= 1'b0;
        cut_level      = '0;
        acc_x          = 0;
        acc_y          = 0;
        acc_z          = 0;
        kept_seen      = 0;
        avg_seen       = 0;
        mismatches     = 0;
        beats_seen     = 0;
        src_idle_pct   = 35;
        sink_idle_pct  = 73;
        no_pin         = '0;
        sent           = 0;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed rows
        foreach (dir_rows[k])
        begin
            if (dir_rows[k].op == ROW_CFG)
            begin
                drain_results();
                write_threshold(dir_rows[k].x[COORD_W-1:0]);
            end
            else
            begin
                pinned      = '0;
                pinned.kind = KIND_CENTROID;
                pinned.x    = dir_rows[k].cx[COORD_W-1:0];
                pinned.y    = dir_rows[k].cy[COORD_W-1:0];
                pinned.z    = dir_rows[k].cz[COORD_W-1:0];
                pinned.kept = dir_rows[k].ck[COUNT_W-1:0];
                pinned.avg  = dir_rows[k].ca[COUNT_W-1:0];
                pinned.none = dir_rows[k].none;
                pinned.fin  = 1'b1;
                send_point(dir_rows[k].x[COORD_W-1:0], dir_rows[k].y[COORD_W-1:0],
                           dir_rows[k].z[COORD_W-1:0], dir_rows[k].last,
                           dir_rows[k].pin, pinned);
            end
        end

        // random clouds; every point sent counts toward the total
        while (sent < RANDOM_ITEMS)
        begin
            if (sent < RANDOM_ITEMS / 3)
            begin
                src_idle_pct  = 35;
                sink_idle_pct = 73;
            end
            else if (sent < 2 * RANDOM_ITEMS / 3)
            begin
                src_idle_pct  = 73;
                sink_idle_pct = 35;
            end
            else
            begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end

            if ($urandom_range(3) == 0)
            begin
                drain_results();
                write_threshold(pick_threshold());
            end

            len     = ($urandom_range(9) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 12);
            mid_cut = ($urandom_range(7) == 0) ? $urandom_range(len - 1) : 0;

            for (int i = 0; i < len; i++)
            begin
                // occasional threshold change inside a cloud
                if (mid_cut != 0 && i == mid_cut)
                begin
                    drain_results();
                    write_threshold(pick_threshold());
                end
                px = pick_coord();
                py = pick_height();
                pz = pick_coord();
                sent++;
                send_point(px, py, pz, (i == len - 1), 1'b0, no_pin);
            end
        end

        drain_results();

        if (mismatches == 0 && expected_beats.size() == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end

endmodule
